// ===== design/wfte_pkg.sv =====
`default_nettype none

package wfte_pkg;

  // Field widths
  localparam int STAMP_W  = 48;
  localparam int BYTES_W  = 48;
  localparam int TPS_W    = 24;
  localparam int SECS_W   = 40;
  localparam int FRAC_W   = 8;
  localparam int STATUS_W = 2;

  // Product widths: free * dt and dsize * ticks_per_second
  localparam int NUM_W = BYTES_W + STAMP_W;
  localparam int DEN_W = BYTES_W + TPS_W;

  // Point ring
  localparam int POINT_DEPTH = 1024;
  localparam int IDX_W       = $clog2(POINT_DEPTH);
  localparam int CNT_W       = $clog2(POINT_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FLAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHRINK = 2'd2;

  localparam logic [SECS_W-1:0] SECS_MAX = '1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 1'b1;

  typedef struct packed {
    logic               new_file;
    logic [STAMP_W-1:0] stamp;
    logic [BYTES_W-1:0] file_bytes;
    logic [BYTES_W-1:0] free_in;
    logic               measure_ok;
  } in_word_t;

  typedef struct packed {
    logic [BYTES_W-1:0]  vol_free;
    logic [SECS_W-1:0]   fill_secs;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [BYTES_W-1:0] size;
  } point_t;

  typedef struct packed {
    logic               start;
    logic [BYTES_W-1:0] free_b;
    logic [STAMP_W-1:0] dt;
    logic [BYTES_W-1:0] dsize;
    logic [TPS_W-1:0]   tps;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mul_rsp_t;

  typedef struct packed {
    logic              done;
    logic [SECS_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_NEW_RD,
    CS_NEW_CMP,
    CS_PRUNE_RD,
    CS_PRUNE_CMP,
    CS_OLD_RD,
    CS_OLD_USE,
    CS_CALC,
    CS_RESULT,
    CS_STORE
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== design/wfte_mul.sv =====
`default_nettype none

module wfte_mul import wfte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int STEP_W = $clog2(STAMP_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [BYTES_W-1:0] free_r;
  logic [BYTES_W-1:0] dsize_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;

  logic [BYTES_W:0]   num_sum;
  logic [BYTES_W:0]   den_sum;
  logic [NUM_W-1:0]   num_step;
  logic [DEN_W-1:0]   den_step;

  // One multiplier bit per cycle: add the multiplicand on a set bit, shift right.
  always_comb begin
    num_sum = {1'b0, num_r[NUM_W-1:STAMP_W]};
    if (num_r[0]) begin
      num_sum = {1'b0, num_r[NUM_W-1:STAMP_W]} + {1'b0, free_r};
    end
    den_sum = {1'b0, den_r[DEN_W-1:TPS_W]};
    if (den_r[0]) begin
      den_sum = {1'b0, den_r[DEN_W-1:TPS_W]} + {1'b0, dsize_r};
    end
    num_step = {num_sum, num_r[STAMP_W-1:1]};
    den_step = {den_sum, den_r[TPS_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(STAMP_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      free_r  <= req.free_b;
      dsize_r <= req.dsize;
      num_r   <= {{BYTES_W{1'b0}}, req.dt};
      den_r   <= {{BYTES_W{1'b0}}, req.tps};
    end else if (busy_r) begin
      num_r <= num_step;
      // the short multiplier runs out early: hold its product
      if (step_r < STEP_W'(TPS_W)) begin
        den_r <= den_step;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.num  = num_r;
  assign rsp.den  = den_r;

endmodule

`default_nettype wire

// ===== design/wfte_div.sv =====
`default_nettype none

module wfte_div import wfte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_rsp_t req,
  output div_rsp_t rsp
);

  // Numerator is num * 2^FRAC_W; its top bits above the quotient width
  // form the first partial remainder.
  localparam int LOW_W  = SECS_W - FRAC_W;
  localparam int HI_W   = NUM_W - LOW_W;
  localparam int PAD_W  = DEN_W - HI_W;
  localparam int STEP_W = $clog2(SECS_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [SECS_W-1:0] low_r;
  logic [SECS_W-1:0] quo_r;

  logic [DEN_W-1:0]  hi_ext;
  logic              sat;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  always_comb begin
    hi_ext = {{PAD_W{1'b0}}, req.num[NUM_W-1:LOW_W]};
    sat    = hi_ext >= req.den;
    trial  = {rem_r, low_r[SECS_W-1]};
    diff   = trial - {1'b0, den_r};
    ge     = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.done) begin
        // quotient would not fit: finish at once with saturation
        busy_r <= !sat;
        done_r <= sat;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SECS_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.done) begin
      den_r <= req.den;
      rem_r <= hi_ext;
      low_r <= {req.num[LOW_W-1:0], {FRAC_W{1'b0}}};
      quo_r <= sat ? SECS_MAX : '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[SECS_W-2:0], 1'b0};
      quo_r <= {quo_r[SECS_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ===== design/wfte_ctrl.sv =====
`default_nettype none

module wfte_ctrl import wfte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  input  logic [STAMP_W-1:0] window_ticks,
  input  logic [TPS_W-1:0]   ticks_per_second,
  output mul_req_t           mul_req,
  input  div_rsp_t           div_rsp,
  output logic               res_valid,
  output out_word_t          res_data,
  input  logic               res_take
);

  // Ring slot base + k, wrapped at the ring depth (k never exceeds the depth)
  function automatic idx_t slot_add(idx_t base, cnt_t k);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, k};
    if (sum >= (CNT_W + 1)'(POINT_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(POINT_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  ctl_state_t state_r, state_nxt;
  idx_t       oldest_r, oldest_nxt;
  cnt_t       count_r, count_nxt;
  logic [STAMP_W-1:0] last_r, last_nxt;
  out_word_t  res_r, res_nxt;
  in_word_t   item_r;

  point_t mem [POINT_DEPTH];
  point_t rd_data_r;
  idx_t   rd_addr;
  idx_t   wr_addr;
  logic   wr_en;
  point_t wr_data;

  idx_t               newest;
  logic               full;
  logic [STAMP_W-1:0] dt;
  logic [BYTES_W-1:0] dsize;
  logic [STAMP_W-1:0] since;
  logic               flat;
  logic               shrink;
  logic               gate;
  logic               expired;

  always_comb begin
    newest  = slot_add(oldest_r, count_r - 1'b1);
    full    = count_r == CNT_W'(POINT_DEPTH);
    dt      = item_r.stamp - rd_data_r.stamp;
    dsize   = item_r.file_bytes - rd_data_r.size;
    flat    = (dt == '0) || (item_r.file_bytes == rd_data_r.size) ||
              (ticks_per_second == '0);
    shrink  = item_r.file_bytes < rd_data_r.size;
    since   = item_r.stamp - last_r;
    gate    = (last_r == '0) ||
              (since >= {{(STAMP_W - TPS_W){1'b0}}, ticks_per_second});
    expired = ({1'b0, rd_data_r.stamp} + {1'b0, window_ticks}) < {1'b0, item_r.stamp};
  end

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    res_nxt    = res_r;
    rd_addr    = oldest_r;
    wr_en      = 1'b0;
    wr_addr    = slot_add(oldest_r, full ? '0 : count_r);
    wr_data    = '{stamp: item_r.stamp, size: item_r.file_bytes};
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mul_req    = '{start: 1'b0, free_b: item_r.free_in, dt: dt,
                   dsize: dsize, tps: ticks_per_second};

    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.new_file) begin
            oldest_nxt = '0;
            count_nxt  = '0;
          end
          state_nxt = CS_NEW_RD;
        end
      end
      CS_NEW_RD: begin
        if (count_r == '0) begin
          state_nxt = CS_OLD_RD;
        end else begin
          rd_addr   = newest;
          state_nxt = CS_NEW_CMP;
        end
      end
      CS_NEW_CMP: begin
        // drop an out-of-order word
        state_nxt = (item_r.stamp < rd_data_r.stamp) ? CS_IDLE : CS_PRUNE_RD;
      end
      CS_PRUNE_RD: begin
        if (count_r > CNT_W'(1)) begin
          state_nxt = CS_PRUNE_CMP;
        end else begin
          state_nxt = CS_OLD_RD;
        end
      end
      CS_PRUNE_CMP: begin
        if (expired) begin
          oldest_nxt = slot_add(oldest_r, CNT_W'(1));
          count_nxt  = count_r - 1'b1;
          state_nxt  = CS_PRUNE_RD;
        end else begin
          state_nxt = CS_OLD_RD;
        end
      end
      CS_OLD_RD: begin
        priority if (!item_r.measure_ok) begin
          state_nxt = CS_IDLE;
        end else if (count_r == '0) begin
          state_nxt = CS_STORE;
        end else begin
          state_nxt = CS_OLD_USE;
        end
      end
      CS_OLD_USE: begin
        if (!gate) begin
          state_nxt = CS_STORE;
        end else begin
          last_nxt          = item_r.stamp;
          res_nxt.vol_free  = item_r.free_in;
          res_nxt.fill_secs = SECS_MAX;
          priority if (flat) begin
            res_nxt.status = ST_FLAT;
            state_nxt      = CS_RESULT;
          end else if (shrink) begin
            res_nxt.status = ST_SHRINK;
            state_nxt      = CS_RESULT;
          end else begin
            res_nxt.status = ST_NORMAL;
            mul_req.start  = 1'b1;
            state_nxt      = CS_CALC;
          end
        end
      end
      CS_CALC: begin
        if (div_rsp.done) begin
          res_nxt.fill_secs = div_rsp.quo;
          state_nxt         = CS_RESULT;
        end
      end
      CS_RESULT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = CS_STORE;
        end
      end
      CS_STORE: begin
        wr_en = 1'b1;
        if (full) begin
          oldest_nxt = slot_add(oldest_r, CNT_W'(1));
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CS_IDLE;
      oldest_r <= '0;
      count_r  <= '0;
      last_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign res_data = res_r;

endmodule

`default_nettype wire

// ===== design/windowed_fill_time_estimator_top.sv =====
// Channel   Handshake              Word
// in_       in_valid / in_ready    in_word_t: new_file, stamp, file_bytes, free_in,
//                                  measure_ok
// out_      out_valid / out_ready  out_word_t: vol_free, fill_secs, status
// cfg_      cfg_wr_en              cfg_index, cfg_wr_data (window_ticks, ticks_per_second)
//
// One word at a time. A stale word is dropped after the compare with the newest point;
// otherwise aged points are pruned one by one, and a word without an estimate stores
// its point or ends there; a no-growth or shrink estimate needs no arithmetic, and else
// the bit-serial multipliers, then the bit-serial divider, set it (cut short on saturation).
// Reset is synchronous, active low; the point ring needs no clearing pass. A full output
// register stalls the result until out_ready; in_ready rises once the result is taken in.
`default_nettype none

module windowed_fill_time_estimator_top import wfte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STAMP_W-1:0]   cfg_wr_data
);

  logic [STAMP_W-1:0] window_r;
  logic [TPS_W-1:0]   tps_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  div_rsp_t  div_rsp;
  logic      res_valid;
  out_word_t res_data;
  logic      res_take;

  // Configuration: plain register writes; the user must write only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= STAMP_W'(1200000);
      tps_r    <= TPS_W'(120000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW: window_r <= cfg_wr_data;
        CFG_TPS:    tps_r    <= cfg_wr_data[TPS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer, point ring and report gate.
  wfte_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .window_ticks     (window_r),
    .ticks_per_second (tps_r),
    .mul_req          (mul_req),
    .div_rsp          (div_rsp),
    .res_valid        (res_valid),
    .res_data         (res_data),
    .res_take         (res_take)
  );

  // free * dt and dsize * ticks_per_second, one multiplier bit a cycle.
  wfte_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Restoring divide, one quotient bit a cycle; starts as the products land.
  wfte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_rsp),
    .rsp   (div_rsp)
  );

  // Output register: take a result when the slot is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_windowed_fill_time_estimator_top.sv =====
module tb_windowed_fill_time_estimator_top;
  import wfte_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Worst busy time of one word that yields no estimate: a prune of the full ring.
  localparam int unsigned SETTLE_CYCLES = 2 * POINT_DEPTH + 200;
  localparam int unsigned EST_DEPTH = 64;

  localparam logic [STAMP_W-1:0] STAMP_TOP     = '1;
  localparam logic [BYTES_W-1:0] BYTES_TOP     = '1;
  localparam logic [STAMP_W-1:0] RESET_WINDOW  = 48'd1200000;
  localparam logic [TPS_W-1:0]   RESET_TPS     = 24'd120000;
  localparam logic [TPS_W-1:0]   TPS_TOP       = '1;

  // Directed rows: the predictor decides, the expectation is typed in, or no word is expected.
  typedef enum logic [1:0] {ROW_PREDICTED, ROW_SILENT, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                nf;
    logic [STAMP_W-1:0]  stamp;
    logic [BYTES_W-1:0]  fbytes;
    logic [BYTES_W-1:0]  freeb;
    logic                ok;
    logic [BYTES_W-1:0]  x_free;
    logic [SECS_W-1:0]   x_secs;
    logic [STATUS_W-1:0] x_status;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [STAMP_W-1:0]   cfg_wr_data = '0;

  // Shadow of the block: point ring, report gate and the two limits.
  logic [STAMP_W-1:0] ring_stamp [POINT_DEPTH];
  logic [BYTES_W-1:0] ring_size [POINT_DEPTH];
  int unsigned        ring_oldest;
  int unsigned        ring_fill;
  logic [STAMP_W-1:0] last_report;
  logic [STAMP_W-1:0] window_ticks_q;
  logic [TPS_W-1:0]   tps_q;

  // Expected words in order: written at est_wr, taken at est_rd.
  out_word_t   est_fifo [EST_DEPTH];
  int unsigned est_wr = 0;
  int unsigned est_rd = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned recv_idle_pct = 0;

  row_t dir_rows [18] = '{
    // first word after reset: no earlier point, nothing to report
    '{ROW_SILENT,    1'b1, 48'd1000,    48'd100,   48'd5000,  1'b1, '0, '0, ST_NORMAL},
    // zero interval while no report was made yet
    '{ROW_TYPED,     1'b0, 48'd1000,    48'd200,   48'd5000,  1'b1,
      48'd5000, SECS_MAX, ST_FLAT},
    // file shrank against the oldest point
    '{ROW_TYPED,     1'b0, 48'd121000,  48'd50,    48'd6000,  1'b1,
      48'd6000, SECS_MAX, ST_SHRINK},
    // same size as the oldest point: no growth
    '{ROW_TYPED,     1'b0, 48'd241000,  48'd100,   48'd7000,  1'b1,
      48'd7000, SECS_MAX, ST_FLAT},
    '{ROW_PREDICTED, 1'b0, 48'd361000,  48'd460,   48'd3000,  1'b1, '0, '0, ST_NORMAL},
    // stale stamp: dropped whole
    '{ROW_SILENT,    1'b0, 48'd5000,    48'd999,   48'd1,     1'b1, '0, '0, ST_NORMAL},
    // failed measurement: no report, no point
    '{ROW_SILENT,    1'b0, 48'd481000,  48'd700,   48'd1,     1'b0, '0, '0, ST_NORMAL},
    // less than a second since the last report
    '{ROW_SILENT,    1'b0, 48'd400000,  48'd480,   48'd2,     1'b1, '0, '0, ST_NORMAL},
    // all free space, one byte of growth: saturate
    '{ROW_TYPED,     1'b0, 48'd1000000, 48'd101,   BYTES_TOP, 1'b1,
      BYTES_TOP, SECS_MAX, ST_NORMAL},
    // window prune down to one point, no free space left
    '{ROW_TYPED,     1'b0, 48'd3000000, 48'd2000,  48'd0,     1'b1, '0, '0, ST_NORMAL},
    '{ROW_PREDICTED, 1'b0, STAMP_TOP,   BYTES_TOP, 48'h5555_5555_5555, 1'b1, '0, '0, ST_NORMAL},
    // new file at stamp zero clears the ring
    '{ROW_SILENT,    1'b1, 48'd0,       48'd0,     48'hAAAA_AAAA_AAAA, 1'b1, '0, '0, ST_NORMAL},
    // gate distance wraps past the top of the stamp range, still short of a second
    '{ROW_SILENT,    1'b0, 48'd5,       48'd10,    48'd1000,  1'b1, '0, '0, ST_NORMAL},
    // wrapped distance reaches exactly one second
    '{ROW_PREDICTED, 1'b0, 48'd119999,  48'd20,    48'd4000,  1'b1, '0, '0, ST_NORMAL},
    // new file below the newest stamp is taken, not treated as stale
    '{ROW_SILENT,    1'b1, 48'd10,      48'd30,    48'd500,   1'b1, '0, '0, ST_NORMAL},
    // new file with a failed measurement leaves the ring empty
    '{ROW_SILENT,    1'b1, 48'd20,      48'd40,    48'd600,   1'b0, '0, '0, ST_NORMAL},
    '{ROW_SILENT,    1'b0, 48'd200000,  48'd50,    48'd1,     1'b1, '0, '0, ST_NORMAL},
    '{ROW_PREDICTED, 1'b0, 48'd400000,  48'd90,    48'd77777, 1'b1, '0, '0, ST_NORMAL}
  };

  windowed_fill_time_estimator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the shadow ring by one accepted word and work out the estimate it yields.
  task automatic predict_estimate(input in_word_t w, output bit emits, output out_word_t est);
    logic [STAMP_W-1:0]        dt;
    logic [STAMP_W-1:0]        gap;
    logic [BYTES_W-1:0]        base_size;
    logic [NUM_W+FRAC_W-1:0]   num;
    logic [NUM_W+FRAC_W-1:0]   quo;
    logic [DEN_W-1:0]          den;
    emits = 1'b0;
    est = '0;
    if (w.new_file) begin
      ring_oldest = 0;
      ring_fill = 0;
    end
    // drop a stale word whole
    if (ring_fill > 0 && w.stamp < ring_stamp[(ring_oldest + ring_fill - 1) % POINT_DEPTH])
      return;
    // prune aged points; the sum must not wrap, so compare one bit wider
    while (ring_fill > 1 &&
           {1'b0, ring_stamp[ring_oldest]} + {1'b0, window_ticks_q} < {1'b0, w.stamp}) begin
      ring_oldest = (ring_oldest + 1) % POINT_DEPTH;
      ring_fill--;
    end
    if (!w.measure_ok)
      return;
    if (ring_fill > 0) begin
      dt = w.stamp - ring_stamp[ring_oldest];
      base_size = ring_size[ring_oldest];
      est.vol_free = w.free_in;
      est.fill_secs = SECS_MAX;
      if (dt == 0 || w.file_bytes == base_size || tps_q == 0) begin
        est.status = ST_FLAT;
      end else if (w.file_bytes < base_size) begin
        est.status = ST_SHRINK;
      end else begin
        est.status = ST_NORMAL;
        // free * dt * 256 over dsize * ticks_per_second, floored and saturated
        num = w.free_in;
        num = (num * dt) << FRAC_W;
        den = w.file_bytes - base_size;
        den = den * tps_q;
        quo = num / den;
        est.fill_secs = (quo > SECS_MAX) ? SECS_MAX : quo[SECS_W-1:0];
      end
      gap = w.stamp - last_report;
      if (last_report == 0 || gap >= tps_q) begin
        emits = 1'b1;
        last_report = w.stamp;
      end
    end
    // full ring: drop the oldest point to make room
    if (ring_fill >= POINT_DEPTH) begin
      ring_oldest = (ring_oldest + 1) % POINT_DEPTH;
      ring_fill = POINT_DEPTH - 1;
    end
    ring_stamp[(ring_oldest + ring_fill) % POINT_DEPTH] = w.stamp;
    ring_size[(ring_oldest + ring_fill) % POINT_DEPTH] = w.file_bytes;
    ring_fill++;
  endtask

  // Append one expected word.
  task automatic expect_word(input out_word_t est);
    est_fifo[est_wr % EST_DEPTH] = est;
    est_wr++;
  endtask

  // Hold the word on the input until it is taken, then predict from it.
  task automatic offer_report(input in_word_t w, output bit emits, output out_word_t est);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_estimate(w, emits, est);
  endtask

  task automatic drain_estimates();
    in_valid <= 1'b0;
    while (est_wr != est_rd) @(posedge clk);
  endtask

  // Write both limits with the block idle; let a long prune finish first.
  task automatic set_limits(input logic [STAMP_W-1:0] window, input logic [TPS_W-1:0] tps);
    drain_estimates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_wr_data <= window;
    @(posedge clk);
    cfg_index <= CFG_TPS;
    cfg_wr_data <= STAMP_W'(tps);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_ticks_q = window;
    tps_q = tps;
  endtask

  // Random stream of reports: mostly one file growing in steps, with new files,
  // stale stamps and failed measurements mixed in.
  task automatic run_reports(input int unsigned count, input int unsigned step_max,
                             input int unsigned new_file_pct, input int unsigned send_idle_pct,
                             input int unsigned recv_idle);
    logic [STAMP_W-1:0] cur_stamp;
    logic [BYTES_W-1:0] cur_size;
    in_word_t           w;
    int unsigned        roll;
    int unsigned        i;
    bit                 emits;
    out_word_t          est;
    cur_stamp = '0;
    cur_size = '0;
    recv_idle_pct = recv_idle;
    for (i = 0; i < count; i++) begin
      // halfway through, hold off until every estimate is back
      if (i == count / 2) begin
        drain_estimates();
      end else if ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      w = '0;
      if (i == 0 || roll < new_file_pct) begin
        w.new_file = 1'b1;
        cur_stamp = STAMP_W'({$urandom(), $urandom()}) >> $urandom_range(0, 47);
        // now and then start just below the top so the stamps run into the wrap
        if (i != 0 && $urandom_range(0, 7) == 0)
          cur_stamp = STAMP_TOP - STAMP_W'($urandom_range(0, 4 * step_max));
        cur_size = BYTES_W'({$urandom(), $urandom()}) >> $urandom_range(0, 47);
        w.stamp = cur_stamp;
      end else if (roll < new_file_pct + 4) begin
        w.stamp = cur_stamp - STAMP_W'($urandom_range(1, step_max + 1));
      end else begin
        cur_stamp = cur_stamp + STAMP_W'($urandom_range(0, step_max));
        case ($urandom_range(0, 9))
          0: cur_size = cur_size - BYTES_W'($urandom_range(1, 1 << 20));
          1: ;
          default: cur_size = cur_size + (BYTES_W'($urandom()) >> $urandom_range(0, 31));
        endcase
        w.stamp = cur_stamp;
      end
      w.file_bytes = cur_size;
      w.free_in = (roll == 99) ? BYTES_TOP :
                  BYTES_W'({$urandom(), $urandom()}) >> $urandom_range(0, 47);
      w.measure_ok = ($urandom_range(0, 99) >= 5);
      offer_report(w, emits, est);
      if (emits)
        expect_word(est);
    end
  endtask

  // Result side: stall at random, compare each taken word with the oldest estimate.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (est_wr == est_rd) begin
          $error("unexpected word: vol_free %0d fill_secs %0d status %0d",
                 out_data.vol_free, out_data.fill_secs, out_data.status);
          mismatches++;
        end else begin
          want = est_fifo[est_rd % EST_DEPTH];
          est_rd++;
          if (out_data.vol_free !== want.vol_free) begin
            $error("vol_free: expected %0d, got %0d", want.vol_free, out_data.vol_free);
            mismatches++;
          end
          if (out_data.fill_secs !== want.fill_secs) begin
            $error("fill_secs: expected %0d, got %0d",
                   want.fill_secs, out_data.fill_secs);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_windowed_fill_time_estimator_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t    w;
    bit          emits;
    out_word_t   est;
    int unsigned r;
    window_ticks_q = RESET_WINDOW;
    tps_q = RESET_TPS;
    ring_oldest = 0;
    ring_fill = 0;
    last_report = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset limits.
    for (r = 0; r < $size(dir_rows); r++) begin
      w.new_file = dir_rows[r].nf;
      w.stamp = dir_rows[r].stamp;
      w.file_bytes = dir_rows[r].fbytes;
      w.free_in = dir_rows[r].freeb;
      w.measure_ok = dir_rows[r].ok;
      offer_report(w, emits, est);
      case (dir_rows[r].kind)
        ROW_PREDICTED: begin
          if (emits)
            expect_word(est);
        end
        ROW_TYPED: begin
          est.vol_free = dir_rows[r].x_free;
          est.fill_secs = dir_rows[r].x_secs;
          est.status = dir_rows[r].x_status;
          expect_word(est);
        end
        default: ;
      endcase
    end

    // Smallest window and interval: heavy pruning, a report on nearly every word.
    set_limits(48'd1, 24'd1);
    run_reports(200, 3, 3, 37, 46);
    // Largest window and interval: nothing ages out, reports are sparse.
    set_limits(STAMP_TOP, TPS_TOP);
    run_reports(200, 2 * TPS_TOP, 3, 46, 37);
    // One long file with no pruning: the ring grows deep.
    set_limits(STAMP_TOP, 24'd3000);
    run_reports(200, 200, 0, 0, 0);
    // Narrow window: points age out within a few words.
    set_limits(48'd5000, 24'd1000);
    run_reports(80, 700, 3, 0, 0);

    drain_estimates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_windowed_fill_time_estimator_top: clean");
    else
      $display("tb_windowed_fill_time_estimator_top: errors");
    $finish;
  end

endmodule
